// File: hw/rtl/cursor_sequence_buffer_macros.svh
// Assertion macros for the cursor sequence buffer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CURSOR_SEQUENCE_BUFFER_MACROS_SVH
`define CURSOR_SEQUENCE_BUFFER_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define CSB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked in the cycle after the antecedent
`define CSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/csb_pkg.sv
// Shared types and constants for the cursor sequence buffer.
// No dependencies; imported by every RTL module of the block.
package csb_pkg;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MD_START   = 3'd0,
    MD_ADVANCE = 3'd1,
    MD_INSERT  = 3'd2,
    MD_ATTACH  = 3'd3,
    MD_REMOVE  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_CUR = 2'd2
  } status_t;

  // What every cell of the chain does on a beat
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

endpackage

// File: hw/rtl/csb_cell.sv
// One storage cell of the shifting chain.
// Depends on csb_pkg for the cell operation codes.
module csb_cell
  import csb_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  cell_op_t             op,
  input  logic [IDX_W-1:0]     pos,
  input  logic [IDX_W-1:0]     cur,
  input  logic [WORD_BITS-1:0] word_in,
  input  logic [WORD_BITS-1:0] low_in,
  input  logic [WORD_BITS-1:0] high_in,
  output logic [WORD_BITS-1:0] word_q,
  output logic [WORD_BITS-1:0] sel_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (op)
      OP_OPEN: begin
        if (MY_IDX == pos) begin
          word_nxt = word_in;
        end else if (MY_IDX > pos) begin
          word_nxt = low_in;
        end
      end
      OP_CLOSE: begin
        if (MY_IDX >= pos) begin
          word_nxt = high_in;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;
  assign sel_q  = (MY_IDX == cur) ? word_r : '0;

endmodule

// File: hw/rtl/csb_ctrl.sv
// Cursor, fill and status registers, plus the chain operation decode.
// Depends on csb_pkg for mode, status and cell operation codes.
module csb_ctrl
  import csb_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [MODE_W-1:0] mode,
  output cell_op_t         op,
  output logic [IDX_W-1:0] pos,
  output logic [IDX_W-1:0] cur,
  output logic             cur_valid,
  output logic [CNT_W-1:0] fill,
  output status_t          status
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] cur_r,   cur_nxt;
  logic             cv_r,    cv_nxt;
  logic [CNT_W-1:0] fill_r,  fill_nxt;
  status_t          stat_r,  stat_nxt;

  logic             full;
  logic [CNT_W-1:0] cur_inc;

  assign full    = (fill_r == FULL_CNT);
  assign cur_inc = CNT_W'(cur_r) + CNT_W'(1);

  always_comb begin
    cur_nxt  = cur_r;
    cv_nxt   = cv_r;
    fill_nxt = fill_r;
    stat_nxt = ST_DONE;
    op       = OP_HOLD;
    pos      = cur_r;
    case (mode)
      MD_START: begin
        cur_nxt = '0;
        cv_nxt  = (fill_r != '0);
      end
      MD_ADVANCE: begin
        if (cv_r) begin
          if (cur_inc < fill_r) begin
            cur_nxt = cur_inc[IDX_W-1:0];
          end else begin
            cur_nxt = '0;
            cv_nxt  = 1'b0;
          end
        end
      end
      MD_INSERT: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          pos      = cv_r ? cur_r : '0;
          op       = OP_OPEN;
          cur_nxt  = pos;
          cv_nxt   = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      MD_ATTACH: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          // not full, so either choice stays below DEPTH
          pos      = cv_r ? cur_inc[IDX_W-1:0] : fill_r[IDX_W-1:0];
          op       = OP_OPEN;
          cur_nxt  = pos;
          cv_nxt   = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      MD_REMOVE: begin
        if (!cv_r) begin
          stat_nxt = ST_NO_CUR;
        end else begin
          op       = OP_CLOSE;
          fill_nxt = fill_r - CNT_W'(1);
          if (cur_inc >= fill_r) begin
            cur_nxt = '0;
            cv_nxt  = 1'b0;
          end
        end
      end
      default: stat_nxt = ST_DONE;
    endcase
    if (!take) begin
      op = OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      cv_r   <= 1'b0;
      fill_r <= '0;
      stat_r <= ST_DONE;
    end else if (take) begin
      cur_r  <= cur_nxt;
      cv_r   <= cv_nxt;
      fill_r <= fill_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign cur       = cur_r;
  assign cur_valid = cv_r;
  assign fill      = fill_r;
  assign status    = stat_r;

endmodule

// File: hw/rtl/cursor_sequence_buffer.sv
// Cursor sequence buffer top level: control, cell chain and output register.
// Depends on csb_pkg, csb_ctrl, csb_cell and cursor_sequence_buffer_macros.svh.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  in_     | in  | entry_value[31:0]                                   | mode[2:0]
//  out_    | out | cursor_value[31:0], has_current, entry_count[5:0],  | -
//          |     | status[1:0], zero pad                               |
//
// The chain shifts at the accepting edge; in S_READ the word at the cursor is
// gathered from the cells and registered once the output register is free.
// rst_n (synchronous) clears cursor, fill and handshake state; cell words are
// left as they are. A stalled output register holds the next input off: no
// beat is taken until the pending result has been loaded.
`include "cursor_sequence_buffer_macros.svh"

module cursor_sequence_buffer
  import csb_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_value[31:0]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // cursor_value[31:0], has_current[32],
                                  // entry_count[38:33], status[40:39]
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fsm_t state_r, state_nxt;
  logic take;
  logic load;

  cell_op_t         op;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] cur;
  logic             cur_valid;
  logic [CNT_W-1:0] fill;
  status_t          status;

  logic [WORD_BITS+31:0] in_ext;
  logic [WORD_BITS-1:0]  word;
  logic [WORD_BITS-1:0]  cell_q [DEPTH];
  logic [WORD_BITS-1:0]  sel_q  [DEPTH];
  logic [WORD_BITS-1:0]  gather;
  logic [WORD_BITS+31:0] gather_ext;
  logic [CNT_W+5:0]      fill_ext;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r;

  assign take   = in_tvalid & in_tready;
  assign in_ext = (WORD_BITS + 32)'(in_tdata);
  assign word   = in_ext[WORD_BITS-1:0];

  csb_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .mode      (in_tuser),
    .op        (op),
    .pos       (pos),
    .cur       (cur),
    .cur_valid (cur_valid),
    .fill      (fill),
    .status    (status)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] low_w;
    logic [WORD_BITS-1:0] high_w;

    if (i == 0) begin : g_first
      assign low_w = '0;
    end else begin : g_mid_lo
      assign low_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign high_w = cell_q[i];
    end else begin : g_mid_hi
      assign high_w = cell_q[i+1];
    end

    csb_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W),
      .IDX       (i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .pos     (pos),
      .cur     (cur),
      .word_in (word),
      .low_in  (low_w),
      .high_in (high_w),
      .word_q  (cell_q[i]),
      .sel_q   (sel_q[i])
    );
  end

  // only the cell under the cursor drives a non-zero word
  always_comb begin
    gather = '0;
    for (int i = 0; i < DEPTH; i++) begin
      gather = gather | sel_q[i];
    end
  end

  assign gather_ext = (WORD_BITS + 32)'(cur_valid ? gather : '0);
  assign fill_ext   = (CNT_W + 6)'(fill);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (take) state_nxt = S_READ;
      S_READ:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    load      = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_READ:  load = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        load      = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {7'b0, status, fill_ext[5:0], cur_valid, gather_ext[31:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `CSB_ASSERT_ALWAYS(a_fill_bound, fill <= CNT_W'(DEPTH), "entry count above depth")

  `CSB_ASSERT_ALWAYS(a_cursor_in_list, !cur_valid || (CNT_W'(cur) < fill),
                     "cursor points past the stored entries")

  `CSB_ASSERT_NEXT(a_accept_blocks, take, !in_tready && state_r == S_READ,
                   "input taken again before the result was gathered")

endmodule
